/* rtl/core/ccir_pkg.sv */
// ============================================================================
// ccir_pkg: shared constants for the circumcircle block
// Result word width and saturation limits used by the divider and top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ccir_pkg;

	localparam int QBITS = 32;

	localparam logic [QBITS-1:0] QPOS_MAX = {1'b0, {(QBITS-1){1'b1}}};
	localparam logic [QBITS-1:0] QNEG_MIN = {1'b1, {(QBITS-1){1'b0}}};

	localparam int DIV_LAT = QBITS + 2;

endpackage

`default_nettype wire

/* rtl/core/ccir_front.sv */
// ============================================================================
// ccir_front: circumcircle front end
// Forms differences, squares, the determinant, both numerators and the
// squared radius numerator over nine registered stages.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ccir_front #(
	parameter int C = 16,
	parameter int F = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_v,
	input  wire logic signed [C-1:0]  first_x,
	input  wire logic signed [C-1:0]  first_y,
	input  wire logic signed [C-1:0]  second_x,
	input  wire logic signed [C-1:0]  second_y,
	input  wire logic signed [C-1:0]  third_x,
	input  wire logic signed [C-1:0]  third_y,
	output logic                      out_v,
	output logic                      deg,
	output logic signed [2*C+3:0]     den,
	output logic signed [3*C+4:0]     negnf,
	output logic signed [3*C+4:0]     ng,
	output logic [2*(3*C+5)+2*F-1:0]  t
);
	import ccir_pkg::*;

	localparam int DW1  = C + 1;
	localparam int SQW  = 2 * C + 2;
	localparam int DENW = 2 * C + 4;
	localparam int MPW  = 3 * C + 3;
	localparam int NW   = 3 * C + 4;
	localparam int AW   = 3 * C + 5;
	localparam int TW   = 2 * AW + 2 * F;
	localparam int LW   = AW / 2;
	localparam int HW   = AW - 1 - LW;
	localparam int SQM  = 2 * (AW - 1);

	logic [9:1] v_q;

	logic signed [C-1:0]     x1_s1, y1_s1;
	logic signed [DW1-1:0]   dx12_s1, dy12_s1, dx13_s1, dy13_s1, y31_s1, y21_s1;
	logic signed [2*C-1:0]   sx1_s1, sx2_s1, sx3_s1, sy1_s1, sy2_s1, sy3_s1;

	logic signed [C-1:0]     x1_s2, y1_s2;
	logic signed [DW1-1:0]   dx12_s2, dy12_s2, dx13_s2, dy13_s2;
	logic signed [SQW-1:0]   s13_s2, s21_s2, p1_s2, p2_s2;

	logic signed [C-1:0]     x1_s3, y1_s3;
	logic signed [DENW-1:0]  den_s3;
	logic signed [MPW-1:0]   m1_s3, m2_s3, m3_s3, m4_s3;

	logic signed [DENW-1:0]  den_s4;
	logic signed [NW-1:0]    nf_s4, ng_s4, xd_s4, yd_s4;

	logic signed [DENW-1:0]  den_s5;
	logic signed [AW-1:0]    a_s5, b_s5, negnf_s5, ng_s5;
	logic                    deg_s5;

	logic signed [DENW-1:0]  den_s6;
	logic signed [AW-1:0]    negnf_s6, ng_s6;
	logic                    deg_s6;
	logic [AW-2:0]           aabs_s6, babs_s6;

	logic signed [DENW-1:0]  den_s7;
	logic signed [AW-1:0]    negnf_s7, ng_s7;
	logic                    deg_s7;
	logic [2*HW-1:0]         ahh_s7, bhh_s7;
	logic [HW+LW-1:0]        ahl_s7, bhl_s7;
	logic [2*LW-1:0]         all_s7, bll_s7;

	logic signed [DENW-1:0]  den_s8;
	logic signed [AW-1:0]    negnf_s8, ng_s8;
	logic                    deg_s8;
	logic [SQM-1:0]          aa_s8, bb_s8;

	logic signed [DENW-1:0]  den_s9;
	logic signed [AW-1:0]    negnf_s9, ng_s9;
	logic                    deg_s9;
	logic [TW-1:0]           t_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[8:1], in_v};
		end
	end

	always_ff @(posedge clk) begin
		x1_s1   <= first_x;
		y1_s1   <= first_y;
		dx12_s1 <= DW1'(first_x) - DW1'(second_x);
		dy12_s1 <= DW1'(first_y) - DW1'(second_y);
		dx13_s1 <= DW1'(first_x) - DW1'(third_x);
		dy13_s1 <= DW1'(first_y) - DW1'(third_y);
		y31_s1  <= DW1'(third_y) - DW1'(first_y);
		y21_s1  <= DW1'(second_y) - DW1'(first_y);
		sx1_s1  <= (2*C)'(first_x) * (2*C)'(first_x);
		sx2_s1  <= (2*C)'(second_x) * (2*C)'(second_x);
		sx3_s1  <= (2*C)'(third_x) * (2*C)'(third_x);
		sy1_s1  <= (2*C)'(first_y) * (2*C)'(first_y);
		sy2_s1  <= (2*C)'(second_y) * (2*C)'(second_y);
		sy3_s1  <= (2*C)'(third_y) * (2*C)'(third_y);

		x1_s2   <= x1_s1;
		y1_s2   <= y1_s1;
		dx12_s2 <= dx12_s1;
		dy12_s2 <= dy12_s1;
		dx13_s2 <= dx13_s1;
		dy13_s2 <= dy13_s1;
		s13_s2  <= SQW'(sx1_s1) - SQW'(sx3_s1) + SQW'(sy1_s1) - SQW'(sy3_s1);
		s21_s2  <= SQW'(sx2_s1) - SQW'(sx1_s1) + SQW'(sy2_s1) - SQW'(sy1_s1);
		p1_s2   <= SQW'(y31_s1) * SQW'(dx12_s1);
		p2_s2   <= SQW'(y21_s1) * SQW'(dx13_s1);

		x1_s3  <= x1_s2;
		y1_s3  <= y1_s2;
		den_s3 <= (DENW'(p1_s2) - DENW'(p2_s2)) <<< 1;
		m1_s3  <= MPW'(s13_s2) * MPW'(dx12_s2);
		m2_s3  <= MPW'(s21_s2) * MPW'(dx13_s2);
		m3_s3  <= MPW'(s13_s2) * MPW'(dy12_s2);
		m4_s3  <= MPW'(s21_s2) * MPW'(dy13_s2);

		den_s4 <= den_s3;
		nf_s4  <= NW'(m1_s3) + NW'(m2_s3);
		ng_s4  <= NW'(m3_s3) + NW'(m4_s3);
		xd_s4  <= NW'(x1_s3) * NW'(den_s3);
		yd_s4  <= NW'(y1_s3) * NW'(den_s3);

		den_s5   <= den_s4;
		deg_s5   <= (den_s4 == '0);
		a_s5     <= AW'(ng_s4) - AW'(xd_s4);
		b_s5     <= -AW'(nf_s4) - AW'(yd_s4);
		negnf_s5 <= -AW'(nf_s4);
		ng_s5    <= AW'(ng_s4);

		den_s6   <= den_s5;
		deg_s6   <= deg_s5;
		negnf_s6 <= negnf_s5;
		ng_s6    <= ng_s5;
		aabs_s6  <= a_s5[AW-1] ? (AW-1)'(-a_s5) : (AW-1)'(a_s5);
		babs_s6  <= b_s5[AW-1] ? (AW-1)'(-b_s5) : (AW-1)'(b_s5);

		den_s7   <= den_s6;
		deg_s7   <= deg_s6;
		negnf_s7 <= negnf_s6;
		ng_s7    <= ng_s6;
		ahh_s7   <= (2*HW)'(aabs_s6[AW-2 -: HW]) * (2*HW)'(aabs_s6[AW-2 -: HW]);
		ahl_s7   <= (HW+LW)'(aabs_s6[AW-2 -: HW]) * (HW+LW)'(aabs_s6[LW-1:0]);
		all_s7   <= (2*LW)'(aabs_s6[LW-1:0]) * (2*LW)'(aabs_s6[LW-1:0]);
		bhh_s7   <= (2*HW)'(babs_s6[AW-2 -: HW]) * (2*HW)'(babs_s6[AW-2 -: HW]);
		bhl_s7   <= (HW+LW)'(babs_s6[AW-2 -: HW]) * (HW+LW)'(babs_s6[LW-1:0]);
		bll_s7   <= (2*LW)'(babs_s6[LW-1:0]) * (2*LW)'(babs_s6[LW-1:0]);

		den_s8   <= den_s7;
		deg_s8   <= deg_s7;
		negnf_s8 <= negnf_s7;
		ng_s8    <= ng_s7;
		aa_s8    <= (SQM'(ahh_s7) << (2 * LW)) + (SQM'(ahl_s7) << (LW + 1))
			+ SQM'(all_s7);
		bb_s8    <= (SQM'(bhh_s7) << (2 * LW)) + (SQM'(bhl_s7) << (LW + 1))
			+ SQM'(bll_s7);

		den_s9   <= den_s8;
		deg_s9   <= deg_s8;
		negnf_s9 <= negnf_s8;
		ng_s9    <= ng_s8;
		t_s9     <= (TW'(aa_s8) + TW'(bb_s8)) << (2 * F);
	end

	assign out_v = v_q[9];
	assign deg   = deg_s9;
	assign den   = den_s9;
	assign negnf = negnf_s9;
	assign ng    = ng_s9;
	assign t     = t_s9;

endmodule

`default_nettype wire

/* rtl/core/ccir_queue.sv */
// ============================================================================
// ccir_queue: two-word queue between front and back
// Decouples the front end from the back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ccir_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              empty,
	output logic              full
);
	import ccir_pkg::*;

	logic [W-1:0] mem [0:1];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop && !empty);
		end
	end

	assign rdata = mem[rp_q];
	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);

endmodule

`default_nettype wire

/* rtl/core/ccir_isqrt.sv */
// ============================================================================
// ccir_isqrt: pipelined integer square root
// One result bit per stage, side word carried alongside.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ccir_isqrt #(
	parameter int TW = 16,
	parameter int SW = 8
) (
	input  wire logic            clk,
	input  wire logic [TW-1:0]   t,
	input  wire logic [SW-1:0]   side_i,
	output logic [TW/2-1:0]      root,
	output logic [SW-1:0]        side_o
);
	import ccir_pkg::*;

	localparam int N  = TW / 2;
	localparam int RW = N + 2;

	logic [RW-1:0] rem_s  [0:N-1];
	logic [N-1:0]  root_s [0:N-1];
	logic [TW-1:0] t_s    [0:N-1];
	logic [SW-1:0] side_s [0:N-1];

	for (genvar k = 0; k < N; k++) begin : g_st
		logic [RW-1:0] r_in, remx, trial;
		logic [N-1:0]  q_in;
		logic [TW-1:0] t_in;
		logic [SW-1:0] s_in;
		logic          ge;

		if (k == 0) begin : g_first
			assign r_in = '0;
			assign q_in = '0;
			assign t_in = t;
			assign s_in = side_i;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign q_in = root_s[k-1];
			assign t_in = t_s[k-1];
			assign s_in = side_s[k-1];
		end

		assign remx  = {r_in[RW-3:0], t_in[TW-1 -: 2]};
		assign trial = {q_in, 2'b01};
		assign ge    = (remx >= trial);

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? remx - trial : remx;
			root_s[k] <= {q_in[N-2:0], ge};
			t_s[k]    <= t_in << 2;
			side_s[k] <= s_in;
		end
	end

	assign root   = root_s[N-1];
	assign side_o = side_s[N-1];

endmodule

`default_nettype wire

/* rtl/core/ccir_div.sv */
// ============================================================================
// ccir_div: pipelined saturating divider
// Restoring division, one quotient bit per stage, truncated toward zero.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ccir_div #(
	parameter int NW  = 16,
	parameter int DW  = 16,
	parameter bit SGN = 1'b1
) (
	input  wire logic                          clk,
	input  wire logic signed [NW-1:0]          n,
	input  wire logic signed [DW-1:0]          d,
	output logic [ccir_pkg::QBITS-1:0]         q
);
	import ccir_pkg::*;

	localparam int MW = ((NW > DW + QBITS) ? NW : DW + QBITS) + 1;

	logic [NW-1:0]    nmag;
	logic [DW-1:0]    dmag;
	logic [MW-1:0]    rem_s [0:QBITS];
	logic [MW-1:0]    md_s  [0:QBITS];
	logic [QBITS-1:0] q_s   [0:QBITS];
	logic             neg_s [0:QBITS];
	logic             ovf_s [0:QBITS];
	logic [QBITS-1:0] qq;

	assign nmag = n[NW-1] ? NW'(-n) : NW'(n);
	assign dmag = d[DW-1] ? DW'(-d) : DW'(d);

	always_ff @(posedge clk) begin
		rem_s[0] <= MW'(nmag);
		md_s[0]  <= MW'(dmag);
		q_s[0]   <= '0;
		neg_s[0] <= n[NW-1] ^ d[DW-1];
		ovf_s[0] <= (MW'(nmag) >= (MW'(dmag) << QBITS));
	end

	for (genvar k = 0; k < QBITS; k++) begin : g_st
		logic [MW-1:0] sh;
		logic          ge;

		assign sh = md_s[k] << (QBITS - 1 - k);
		assign ge = (rem_s[k] >= sh);

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? rem_s[k] - sh : rem_s[k];
			q_s[k+1]   <= {q_s[k][QBITS-2:0], ge};
			md_s[k+1]  <= md_s[k];
			neg_s[k+1] <= neg_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	assign qq = ovf_s[QBITS] ? '1 : q_s[QBITS];

	always_ff @(posedge clk) begin
		if (!SGN) begin
			q <= qq;
		end else if (!neg_s[QBITS]) begin
			q <= qq[QBITS-1] ? QPOS_MAX : qq;
		end else begin
			q <= qq[QBITS-1] ? QNEG_MIN : QBITS'(-qq);
		end
	end

endmodule

`default_nettype wire

/* rtl/core/ccir_back.sv */
// ============================================================================
// ccir_back: circumcircle back end
// Square root of the radius numerator, then three dividers in lockstep.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ccir_back #(
	parameter int DENW = 36,
	parameter int AW   = 53,
	parameter int TW   = 122
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_v,
	input  wire logic                            deg,
	input  wire logic signed [DENW-1:0]          den,
	input  wire logic signed [AW-1:0]            negnf,
	input  wire logic signed [AW-1:0]            ng,
	input  wire logic [TW-1:0]                   t,
	output logic                                 done,
	output logic signed [ccir_pkg::QBITS-1:0]    center_x,
	output logic signed [ccir_pkg::QBITS-1:0]    center_y,
	output logic [ccir_pkg::QBITS-1:0]           radius,
	output logic                                 degenerate
);
	import ccir_pkg::*;

	localparam int N  = TW / 2;
	localparam int SW = DENW + 2 * AW;
	localparam int L  = N + DIV_LAT;

	logic [N-1:0]          root;
	logic [SW-1:0]         side;
	logic signed [DENW-1:0] den_r;
	logic signed [AW-1:0]   negnf_r, ng_r;
	logic [QBITS-1:0]      qx, qy, qr;
	logic [L-1:0]          v_q;
	logic [L-1:0]          deg_q;

	ccir_isqrt #(.TW(TW), .SW(SW)) u_sqrt (
		.clk    (clk),
		.t      (t),
		.side_i ({den, negnf, ng}),
		.root   (root),
		.side_o (side)
	);

	assign {den_r, negnf_r, ng_r} = side;

	ccir_div #(.NW(AW), .DW(DENW), .SGN(1'b1)) u_div_x (
		.clk (clk), .n (ng_r), .d (den_r), .q (qx)
	);

	ccir_div #(.NW(AW), .DW(DENW), .SGN(1'b1)) u_div_y (
		.clk (clk), .n (negnf_r), .d (den_r), .q (qy)
	);

	ccir_div #(.NW(N + 1), .DW(DENW), .SGN(1'b0)) u_div_r (
		.clk (clk), .n ({1'b0, root}), .d (den_r), .q (qr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q  <= '0;
			done <= 1'b0;
		end else begin
			v_q  <= {v_q[L-2:0], in_v};
			done <= v_q[L-1];
		end
	end

	always_ff @(posedge clk) begin
		deg_q      <= {deg_q[L-2:0], deg};
		degenerate <= deg_q[L-1];
		center_x   <= deg_q[L-1] ? '0 : qx;
		center_y   <= deg_q[L-1] ? '0 : qy;
		radius     <= deg_q[L-1] ? '0 : qr;
	end

endmodule

`default_nettype wire

/* rtl/core/circumcircle_of_three_points_top.sv */
// ============================================================================
// circumcircle_of_three_points_top: circle through three integer points
// Centre truncated toward zero and saturated, radius in unsigned fixed point.
// ============================================================================
// Usage:
//   Drive the six coordinates and raise start; the word is taken at a rising
//   edge where start is high and busy is low. busy is low in normal running,
//   so one word may be taken every cycle.
//   Each result appears for exactly one cycle with done high; the receiver
//   cannot stall, so results are never held.
//   A word passes through the 9 front stages, the queue, (3*COORD_BITS + 5 +
//   RADIUS_FRAC_BITS) square-root stages, 34 divider stages and 1 output
//   register.
//   Throughput: one word per cycle, set by the fully pipelined square-root
//   and divider stages.
//   Collinear points give degenerate high with all other results zero.
//   Reset clears all valid flags; words in flight are dropped.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module circumcircle_of_three_points_top #(
	parameter int COORD_BITS       = 16,
	parameter int RADIUS_FRAC_BITS = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [COORD_BITS-1:0]        first_x,
	input  wire logic signed [COORD_BITS-1:0]        first_y,
	input  wire logic signed [COORD_BITS-1:0]        second_x,
	input  wire logic signed [COORD_BITS-1:0]        second_y,
	input  wire logic signed [COORD_BITS-1:0]        third_x,
	input  wire logic signed [COORD_BITS-1:0]        third_y,
	output logic                                     done,
	output logic signed [ccir_pkg::QBITS-1:0]        center_x,
	output logic signed [ccir_pkg::QBITS-1:0]        center_y,
	output logic [ccir_pkg::QBITS-1:0]               radius,
	output logic                                     degenerate
);
	import ccir_pkg::*;

	localparam int C    = COORD_BITS;
	localparam int F    = RADIUS_FRAC_BITS;
	localparam int DENW = 2 * C + 4;
	localparam int AW   = 3 * C + 5;
	localparam int TW   = 2 * AW + 2 * F;
	localparam int QW   = 1 + DENW + 2 * AW + TW;

	logic                   f_v, f_deg;
	logic signed [DENW-1:0] f_den, b_den;
	logic signed [AW-1:0]   f_negnf, f_ng, b_negnf, b_ng;
	logic [TW-1:0]          f_t, b_t;
	logic                   b_deg;
	logic [QW-1:0]          q_rdata;
	logic                   q_empty, q_full;

	assign busy = q_full;

	ccir_front #(.C(C), .F(F)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (start && !busy),
		.first_x  (first_x),
		.first_y  (first_y),
		.second_x (second_x),
		.second_y (second_y),
		.third_x  (third_x),
		.third_y  (third_y),
		.out_v    (f_v),
		.deg      (f_deg),
		.den      (f_den),
		.negnf    (f_negnf),
		.ng       (f_ng),
		.t        (f_t)
	);

	ccir_queue #(.W(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_v),
		.wdata  ({f_deg, f_den, f_negnf, f_ng, f_t}),
		.pop    (!q_empty),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (q_full)
	);

	assign {b_deg, b_den, b_negnf, b_ng, b_t} = q_rdata;

	ccir_back #(.DENW(DENW), .AW(AW), .TW(TW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_v       (!q_empty),
		.deg        (b_deg),
		.den        (b_den),
		.negnf      (b_negnf),
		.ng         (b_ng),
		.t          (b_t),
		.done       (done),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius     (radius),
		.degenerate (degenerate)
	);

endmodule

`default_nettype wire
